// ===== design/gif_tag_packet_unpacker_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the tag packet unpacker
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GIF_TAG_PACKET_UNPACKER_DEFINES_SVH
`define GIF_TAG_PACKET_UNPACKER_DEFINES_SVH

// same-cycle implication
`define GTPU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtpu assertion failed");

// next-cycle implication
`define GTPU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtpu assertion failed");

`endif

// ===== design/gtpu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtpu_pkg
// Shared types and constants of the tag packet unpacker.
// ---------------------------------------------------------------------------
package gtpu_pkg;

    localparam logic [1:0]  KIND_REG   = 2'd0;
    localparam logic [1:0]  KIND_IMAGE = 2'd1;
    localparam logic [1:0]  KIND_NONE  = 2'd2;

    localparam logic [31:0] Q_ONE      = 32'h3F80_0000;

    typedef struct packed {
        logic [14:0] loops_left;
        logic [1:0]  mode;
        logic [4:0]  reg_count;
        logic [4:0]  regs_left;
        logic [63:0] descriptor_list;
        logic        end_flag;
        logic [31:0] q_hold;
    } gtpu_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  reg_addr;
        logic [63:0] data;
        logic        packet_end;
        logic        last;
    } gtpu_result_t;

endpackage

// ===== design/gtpu_decode.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtpu_decode
// Decodes one qword against the current packet state: tag, packed,
// register-list or image data. Produces one or two results and the next state.
// ---------------------------------------------------------------------------
module gtpu_decode
    import gtpu_pkg::*;
(
    input  gtpu_state_t  st,
    input  logic [31:0]  word0,
    input  logic [31:0]  word1,
    input  logic [31:0]  word2,
    input  logic [31:0]  word3,
    output gtpu_state_t  st_next,
    output gtpu_result_t res0,
    output gtpu_result_t res1,
    output logic         two
);

    localparam logic [1:0] MODE_PACKED  = 2'd0;
    localparam logic [1:0] MODE_REGLIST = 2'd1;

    localparam logic [3:0] DESC_PRIM    = 4'h0;
    localparam logic [3:0] DESC_RGBAQ   = 4'h1;
    localparam logic [3:0] DESC_ST      = 4'h2;
    localparam logic [3:0] DESC_UV      = 4'h3;
    localparam logic [3:0] DESC_XYZF2   = 4'h4;
    localparam logic [3:0] DESC_XYZ2    = 4'h5;
    localparam logic [3:0] DESC_TEX0_1  = 4'h6;
    localparam logic [3:0] DESC_TEX0_2  = 4'h7;
    localparam logic [3:0] DESC_CLAMP_1 = 4'h8;
    localparam logic [3:0] DESC_CLAMP_2 = 4'h9;
    localparam logic [3:0] DESC_FOG     = 4'hA;
    localparam logic [3:0] DESC_XYZF3   = 4'hC;
    localparam logic [3:0] DESC_XYZ3    = 4'hD;
    localparam logic [3:0] DESC_AD      = 4'hE;
    localparam logic [3:0] DESC_NOP     = 4'hF;

    localparam logic [7:0] REG_PRIM  = 8'h00;
    localparam logic [7:0] REG_RGBAQ = 8'h01;
    localparam logic [7:0] REG_ST    = 8'h02;
    localparam logic [7:0] REG_UV    = 8'h03;
    localparam logic [7:0] REG_XYZF2 = 8'h04;
    localparam logic [7:0] REG_XYZ2  = 8'h05;
    localparam logic [7:0] REG_FOG   = 8'h0A;
    localparam logic [7:0] REG_XYZF3 = 8'h0C;
    localparam logic [7:0] REG_XYZ3  = 8'h0D;

    typedef struct packed {
        logic [14:0] loops;
        logic [4:0]  rl;
    } walk_t;

    // repair an out-of-range register counter
    function automatic logic [4:0] fix_rl(input logic [4:0] rl, input logic [4:0] rc);
        fix_rl = (rl == 5'd0 || rl > rc) ? rc : rl;
    endfunction

    function automatic logic [3:0] pick_desc(input logic [63:0] dl,
                                             input logic [4:0]  rc,
                                             input logic [4:0]  rl);
        logic [4:0]  diff;
        logic [63:0] sh;
        diff      = rc - rl;
        sh        = dl >> {diff[3:0], 2'b00};
        pick_desc = sh[3:0];
    endfunction

    function automatic walk_t advance(input logic [14:0] loops,
                                      input logic [4:0]  rl,
                                      input logic [4:0]  rc);
        walk_t w;
        w.loops = loops;
        w.rl    = (rl != 5'd0) ? rl - 5'd1 : rl;
        if (w.rl == 5'd0)
        begin
            w.loops = loops - 15'd1;
            w.rl    = rc;
        end
        advance = w;
    endfunction

    logic [63:0]  d0;
    logic [63:0]  d1;
    logic [4:0]   rl0;
    logic [4:0]   rl1;
    logic [3:0]   desc0;
    logic [3:0]   desc1;
    walk_t        adv0;
    walk_t        adv1;
    logic [3:0]   nreg;
    logic         done;
    logic         pe;

    assign d0 = {word1, word0};
    assign d1 = {word3, word2};

    always_comb
    begin
        st_next = st;
        res0    = '0;
        res1    = '0;
        res0.kind = KIND_NONE;
        res1.kind = KIND_NONE;
        two     = 1'b0;
        done    = 1'b0;
        nreg    = word1[31:28];
        rl0     = fix_rl(st.regs_left, st.reg_count);
        desc0   = pick_desc(st.descriptor_list, st.reg_count, rl0);
        adv0    = advance(st.loops_left, rl0, st.reg_count);
        rl1     = fix_rl(adv0.rl, st.reg_count);
        desc1   = pick_desc(st.descriptor_list, st.reg_count, rl1);
        adv1    = advance(adv0.loops, rl1, st.reg_count);

        if (st.loops_left == 15'd0)
        begin
            // packet tag
            st_next.loops_left      = word0[14:0];
            st_next.end_flag        = word0[15];
            st_next.mode            = word1[27:26];
            st_next.reg_count       = (nreg == 4'd0) ? 5'd16 : {1'b0, nreg};
            st_next.regs_left       = st_next.reg_count;
            st_next.descriptor_list = d1;
            st_next.q_hold          = Q_ONE;
            if (word1[27:26] != MODE_REGLIST && word1[14])
            begin
                res0.kind     = KIND_REG;
                res0.reg_addr = REG_PRIM;
                res0.data     = {53'd0, word1[25:15]};
            end
            done = (word0[14:0] == 15'd0);
        end
        else
        begin
            case (st.mode)
                MODE_PACKED:
                begin
                    res0.kind = KIND_REG;
                    res0.data = d0;
                    case (desc0)
                        DESC_PRIM:  res0.reg_addr = REG_PRIM;
                        DESC_RGBAQ:
                        begin
                            res0.reg_addr = REG_RGBAQ;
                            res0.data     = {st.q_hold, word3[7:0], word2[7:0],
                                             word1[7:0], word0[7:0]};
                        end
                        DESC_ST:
                        begin
                            res0.reg_addr  = REG_ST;
                            st_next.q_hold = word2;
                        end
                        DESC_UV:
                        begin
                            res0.reg_addr = REG_UV;
                            res0.data     = {32'd0, 1'b0, word1[14:0], 1'b0, word0[14:0]};
                        end
                        DESC_XYZF2:
                        begin
                            res0.reg_addr = word3[15] ? REG_XYZF3 : REG_XYZF2;
                            res0.data     = {word3[11:4], word2[27:4],
                                             word1[15:0], word0[15:0]};
                        end
                        DESC_XYZ2:
                        begin
                            res0.reg_addr = word3[15] ? REG_XYZ3 : REG_XYZ2;
                            res0.data     = {word2, word1[15:0], word0[15:0]};
                        end
                        DESC_TEX0_1, DESC_TEX0_2, DESC_CLAMP_1, DESC_CLAMP_2,
                        DESC_XYZF3, DESC_XYZ3:
                            res0.reg_addr = {4'd0, desc0};
                        DESC_FOG:
                        begin
                            res0.reg_addr = REG_FOG;
                            res0.data     = {word3[11:4], 56'd0};
                        end
                        DESC_AD:    res0.reg_addr = word2[7:0];
                        default:
                        begin
                            // reserved and NOP slots
                            res0 = '0;
                            res0.kind = KIND_NONE;
                        end
                    endcase
                    st_next.loops_left = adv0.loops;
                    st_next.regs_left  = adv0.rl;
                    done = (adv0.loops == 15'd0);
                end
                MODE_REGLIST:
                begin
                    two = 1'b1;
                    if (desc0 != DESC_NOP)
                    begin
                        res0.kind     = KIND_REG;
                        res0.reg_addr = {4'd0, desc0};
                        res0.data     = d0;
                    end
                    if (adv0.loops == 15'd0)
                    begin
                        // high half is padding
                        st_next.loops_left = adv0.loops;
                        st_next.regs_left  = adv0.rl;
                        done = 1'b1;
                    end
                    else
                    begin
                        if (desc1 != DESC_NOP)
                        begin
                            res1.kind     = KIND_REG;
                            res1.reg_addr = {4'd0, desc1};
                            res1.data     = d1;
                        end
                        st_next.loops_left = adv1.loops;
                        st_next.regs_left  = adv1.rl;
                        done = (adv1.loops == 15'd0);
                    end
                end
                default:
                begin
                    // image data
                    two = 1'b1;
                    res0.kind = KIND_IMAGE;
                    res0.data = d0;
                    res1.kind = KIND_IMAGE;
                    res1.data = d1;
                    st_next.loops_left = st.loops_left - 15'd1;
                    done = (st_next.loops_left == 15'd0);
                end
            endcase
        end

        pe = done && st_next.end_flag;
        if (done)
            st_next.end_flag = 1'b0;
        res0.packet_end = pe;
        res1.packet_end = pe;
        res0.last       = !two;
        res1.last       = 1'b1;
    end

endmodule

// ===== design/gif_tag_packet_unpacker.sv =====
// An input qword is captured in the input register, then decoded into the result buffer.
// Throughput: one qword per cycle for tags and packed data while out_stall is low;
// register-list and image qwords wait on the one-result-per-transfer output, two results each.
// Reset clears all loop and register counters, so the first qword is a tag;
// the held Q value resets to 1.0.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gif_tag_packet_unpacker
// Input register, single-pass qword decode, two-slot result buffer.
// ---------------------------------------------------------------------------
`include "gif_tag_packet_unpacker_defines.svh"

module gif_tag_packet_unpacker
    import gtpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] word0,
    input  logic [31:0] word1,
    input  logic [31:0] word2,
    input  logic [31:0] word3,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  reg_addr,
    output logic [63:0] data,
    output logic        packet_end,
    output logic        last
);

    logic         in_vld_reg;
    logic         in_vld_next;
    logic [31:0]  word0_reg;
    logic [31:0]  word1_reg;
    logic [31:0]  word2_reg;
    logic [31:0]  word3_reg;

    gtpu_state_t  state_reg;
    gtpu_state_t  state_next;

    gtpu_result_t slot0_reg;
    gtpu_result_t slot0_next;
    gtpu_result_t slot1_reg;
    gtpu_result_t slot1_next;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    gtpu_result_t dec_res0;
    gtpu_result_t dec_res1;
    logic         dec_two;

    logic         in_xfer;
    logic         out_xfer;
    logic         dec_fire;

    gtpu_decode u_decode (
        .st      (state_reg),
        .word0   (word0_reg),
        .word1   (word1_reg),
        .word2   (word2_reg),
        .word3   (word3_reg),
        .st_next (state_next),
        .res0    (dec_res0),
        .res1    (dec_res1),
        .two     (dec_two)
    );

    assign out_valid = (cnt_reg != 2'd0);
    assign out_xfer  = out_valid && !out_stall;
    // decode when the buffer is empty or its last entry leaves this cycle
    assign dec_fire  = in_vld_reg && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_xfer));
    assign in_stall  = in_vld_reg && !dec_fire;
    assign in_xfer   = in_valid && !in_stall;

    assign kind       = slot0_reg.kind;
    assign reg_addr   = slot0_reg.reg_addr;
    assign data       = slot0_reg.data;
    assign packet_end = slot0_reg.packet_end;
    assign last       = slot0_reg.last;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_xfer)
            in_vld_next = 1'b1;
        else if (dec_fire)
            in_vld_next = 1'b0;
    end

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (dec_fire)
        begin
            slot0_next = dec_res0;
            slot1_next = dec_res1;
            cnt_next   = dec_two ? 2'd2 : 2'd1;
        end
        else if (out_xfer)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            state_reg  <= '{loops_left: 15'd0, mode: 2'd0, reg_count: 5'd0,
                            regs_left: 5'd0, descriptor_list: 64'd0,
                            end_flag: 1'b0, q_hold: Q_ONE};
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            cnt_reg    <= cnt_next;
            if (dec_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            word0_reg <= word0;
            word1_reg <= word1;
            word2_reg <= word2;
            word3_reg <= word3;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // a result that is not the last of its qword has its partner queued
    `GTPU_ASSERT_NOW(a_notlast_has_pair, out_valid && !last, cnt_reg == 2'd2)
    // the queued second result always closes its qword
    `GTPU_ASSERT_NOW(a_pair_closes, cnt_reg == 2'd2, slot1_reg.last)
    // a decoded qword shows up on the output in the next cycle
    `GTPU_ASSERT_NEXT(a_decode_shows, dec_fire, out_valid)

endmodule
